// ----- src/mexp_pkg.sv -----
// mexp_pkg: shared widths and types for the modular exponentiation block
// used by mexp_mulmod and modular_exponentiation; no dependencies
package mexp_pkg;

  localparam int WIDTH = 63;
  localparam int CNT_W = $clog2(WIDTH);
  localparam int ADDR_W = 4;
  localparam int DATA_W = 64;

  localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(WIDTH - 1);

  // start request to the modular multiplier
  typedef struct packed {
    logic             start;
    logic [WIDTH-1:0] x;
    logic [WIDTH-1:0] y;
  } mm_req_t;

endpackage

// ----- src/mexp_mulmod.sv -----
// mexp_mulmod: serial modular multiplier, one multiplier bit per cycle
// (double, conditionally add, reduce); depends on mexp_pkg
module mexp_mulmod import mexp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  mm_req_t          req,
  input  logic [WIDTH-1:0] modulus,
  output logic             done,
  output logic [WIDTH-1:0] product
);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] x;
  logic [WIDTH-1:0] y;
  logic [WIDTH-1:0] acc_next;

  logic [WIDTH+1:0] sum;
  logic [WIDTH+1:0] m1;
  logic [WIDTH+1:0] m2;

  // acc and x stay below the modulus, so 2*acc + x is below 3*modulus
  always_comb begin
    sum = {1'b0, acc, 1'b0} + (y[WIDTH-1] ? {2'b00, x} : '0);
    m1  = {2'b00, modulus};
    m2  = {1'b0, modulus, 1'b0};
    if (sum >= m2) begin
      acc_next = WIDTH'(sum - m2);
    end else if (sum >= m1) begin
      acc_next = WIDTH'(sum - m1);
    end else begin
      acc_next = sum[WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= LAST_BIT;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc <= '0;
      x   <= req.x;
      y   <= req.y;
    end else if (busy) begin
      acc <= acc_next;
      y   <= {y[WIDTH-2:0], 1'b0};
    end
  end

  assign product = acc;

endmodule

// ----- src/modular_exponentiation.sv -----
// modular_exponentiation: square-and-multiply over a configured exponent and modulus
// depends on mexp_pkg and mexp_mulmod
//
// usage:
//   configure modulus (byte address 0) and exponent (byte address 8) over the
//   apb port while no transaction is in flight; data is 64 bits, upper bit ignored
//   base channel: base_valid/base_stall; one base per transaction
//   power channel: power_valid/power_stall; one power per base
//   the base is first reduced by the modulus, then all exponent bits are
//   scanned from the top: a square per bit, and a multiply where the bit is set
//   every modular product goes through one shared serial multiplier that takes
//   one multiplier bit per cycle
//   base_stall drops in the same cycle that power_valid rises
//   one base at a time; base_stall is high from acceptance until the result
//   is moved into the output register
//   a stalled power holds; the next base is taken while it waits
//   modulus below two gives power zero; exponent zero gives one
//   reset: modulus 2, exponent 0, output empty, ready for a base
module modular_exponentiation import mexp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              base_valid,
  output logic              base_stall,
  input  logic [WIDTH-1:0]  base,
  output logic              power_valid,
  input  logic              power_stall,
  output logic [WIDTH-1:0]  power
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_REDUCE = 5'b00010,
    S_SQUARE = 5'b00100,
    S_MULT   = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  localparam logic [WIDTH-1:0] ONE = WIDTH'(1);

  state_t           state;
  logic [WIDTH-1:0] modulus;
  logic [WIDTH-1:0] exponent;
  logic [WIDTH-1:0] base_red;
  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] exp_sh;
  logic [CNT_W-1:0] ecnt;

  mm_req_t          req;
  logic             mm_done;
  logic [WIDTH-1:0] product;

  mexp_mulmod u_mulmod (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .modulus (modulus),
    .done    (mm_done),
    .product (product)
  );

  // apb register file
  assign pready = 1'b1;
  assign prdata = paddr[3] ? {1'b0, exponent} : {1'b0, modulus};

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus  <= WIDTH'(2);
      exponent <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[3]) begin
        exponent <= pwdata[WIDTH-1:0];
      end else begin
        modulus <= pwdata[WIDTH-1:0];
      end
    end
  end

  assign base_stall = (state != S_IDLE);

  // multiplier requests
  always_comb begin
    req = '0;
    unique case (state)
      S_IDLE: begin
        if (base_valid) begin
          // base * 1 mod m reduces the base
          req.start = 1'b1;
          req.x     = ONE;
          req.y     = base;
        end
      end
      S_REDUCE: begin
        if (mm_done) begin
          req.start = 1'b1;
          req.x     = acc;
          req.y     = acc;
        end
      end
      S_SQUARE: begin
        if (mm_done) begin
          if (exp_sh[WIDTH-1]) begin
            req.start = 1'b1;
            req.x     = base_red;
            req.y     = product;
          end else if (ecnt != '0) begin
            req.start = 1'b1;
            req.x     = product;
            req.y     = product;
          end
        end
      end
      S_MULT: begin
        if (mm_done && ecnt != '0) begin
          req.start = 1'b1;
          req.x     = product;
          req.y     = product;
        end
      end
      S_DONE: begin
        req = '0;
      end
      default: begin
        req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      power_valid <= 1'b0;
      ecnt        <= '0;
    end else begin
      if (state == S_DONE && (!power_valid || !power_stall)) begin
        power_valid <= 1'b1;
      end else if (power_valid && !power_stall) begin
        power_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (base_valid) begin
            ecnt  <= LAST_BIT;
            state <= S_REDUCE;
          end
        end
        S_REDUCE: begin
          if (mm_done) begin
            state <= S_SQUARE;
          end
        end
        S_SQUARE: begin
          if (mm_done) begin
            if (exp_sh[WIDTH-1]) begin
              state <= S_MULT;
            end else if (ecnt == '0) begin
              state <= S_DONE;
            end else begin
              ecnt <= ecnt - 1'b1;
            end
          end
        end
        S_MULT: begin
          if (mm_done) begin
            if (ecnt == '0) begin
              state <= S_DONE;
            end else begin
              ecnt  <= ecnt - 1'b1;
              state <= S_SQUARE;
            end
          end
        end
        S_DONE: begin
          if (!power_valid || !power_stall) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (base_valid) begin
          acc    <= ONE;
          exp_sh <= exponent;
        end
      end
      S_REDUCE: begin
        if (mm_done) begin
          base_red <= product;
        end
      end
      S_SQUARE: begin
        if (mm_done) begin
          acc <= product;
          if (!exp_sh[WIDTH-1]) begin
            exp_sh <= {exp_sh[WIDTH-2:0], 1'b0};
          end
        end
      end
      S_MULT: begin
        if (mm_done) begin
          acc    <= product;
          exp_sh <= {exp_sh[WIDTH-2:0], 1'b0};
        end
      end
      S_DONE: begin
        if (!power_valid || !power_stall) begin
          // every value is zero modulo one; modulus zero yields zero too
          power <= (modulus < WIDTH'(2)) ? '0 : acc;
        end
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// testbench: random and directed checks of modular_exponentiation (base^exponent mod modulus)
// depends on mexp_pkg and modular_exponentiation; a square-and-multiply predictor runs alongside

module testbench import mexp_pkg::*; ();

  localparam logic [ADDR_W-1:0] MODULUS_ADDR = ADDR_W'(0);
  localparam logic [ADDR_W-1:0] EXPONENT_ADDR = ADDR_W'(8);
  localparam logic [WIDTH-1:0] VALUE_MAX = '1;
  localparam int CYCLE_LIMIT = 5_000_000;
  localparam int DRAIN_CYCLES = 16;

  logic              clk;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              base_valid = 1'b0;
  logic              base_stall;
  logic [WIDTH-1:0]  base = '0;
  logic              power_valid;
  logic              power_stall = 1'b0;
  logic [WIDTH-1:0]  power;

  // register copies used for prediction
  logic [WIDTH-1:0] modulus_cfg = WIDTH'(2);
  logic [WIDTH-1:0] exponent_cfg = '0;

  logic [WIDTH-1:0] power_q[$];
  logic [WIDTH-1:0] power_want;
  int error_count = 0;
  int cycle_count = 0;
  int stall_left = 0;
  bit no_idle = 1'b0;

  modular_exponentiation u_dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .base_valid (base_valid),
    .base_stall (base_stall),
    .base       (base),
    .power_valid(power_valid),
    .power_stall(power_stall),
    .power      (power)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // (x + y) mod m for x, y below m, kept inside 64 bits
  function automatic logic [63:0] addmod(input logic [63:0] x, input logic [63:0] y,
                                         input logic [63:0] m);
    logic [63:0] room;
    room = m - y;
    return (x >= room) ? x - room : x + y;
  endfunction

  // (x * y) mod m by doubling and adding from the top multiplier bit
  function automatic logic [63:0] mulmod(input logic [63:0] x, input logic [63:0] y,
                                         input logic [63:0] m);
    logic [63:0] acc;
    int i;
    acc = '0;
    for (i = WIDTH - 1; i >= 0; i--) begin
      acc = addmod(acc, acc, m);
      if (y[i]) acc = addmod(acc, x, m);
    end
    return acc;
  endfunction

  function automatic logic [WIDTH-1:0] modpow(input logic [WIDTH-1:0] b,
                                              input logic [WIDTH-1:0] e,
                                              input logic [WIDTH-1:0] m);
    logic [63:0] acc;
    logic [63:0] rb;
    int i;
    if (m < 2) return '0;
    rb = {1'b0, b} % {1'b0, m};
    acc = 64'd1;
    for (i = WIDTH - 1; i >= 0; i--) begin
      acc = mulmod(acc, acc, {1'b0, m});
      if (e[i]) acc = mulmod(acc, rb, {1'b0, m});
    end
    return acc[WIDTH-1:0];
  endfunction

  function automatic logic [WIDTH-1:0] rand_value();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[WIDTH-1:0];
  endfunction

  function automatic logic [WIDTH-1:0] rand_narrow();
    return rand_value() >> $urandom_range(0, WIDTH - 1);
  endfunction

  task automatic report_mismatch(input string what, input logic [WIDTH-1:0] got,
                                 input logic [WIDTH-1:0] want);
    $display("mismatch: %s got %0d expected %0d (cycle %0d)", what, got, want, cycle_count);
    error_count++;
  endtask

  // write one register, then read it back; psel stays high between the two
  task automatic set_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] value);
    logic [WIDTH-1:0] mirror;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == MODULUS_ADDR) modulus_cfg = value[WIDTH-1:0];
    else if (addr == EXPONENT_ADDR) exponent_cfg = value[WIDTH-1:0];
    mirror = (addr == MODULUS_ADDR) ? modulus_cfg : exponent_cfg;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[WIDTH-1:0] !== mirror) report_mismatch("register readback", prdata[WIDTH-1:0],
                                                      mirror);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (power_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(input logic [WIDTH-1:0] m, input logic [WIDTH-1:0] e);
    base_valid <= 1'b0;
    wait_drained();
    set_reg(MODULUS_ADDR, {1'b0, m});
    set_reg(EXPONENT_ADDR, {1'b0, e});
  endtask

  // one base transaction; returns at the edge where it is accepted
  task automatic send_base(input logic [WIDTH-1:0] value);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      base_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    base <= value;
    base_valid <= 1'b1;
    do @(posedge clk); while (base_stall);
    power_q = {power_q, modpow(value, exponent_cfg, modulus_cfg)};
  endtask

  task automatic test_reset_state();
    send_base('0);
    send_base(WIDTH'(5));
    send_base(VALUE_MAX);
  endtask

  task automatic test_exponent_zero();
    configure(VALUE_MAX, '0);
    send_base('0);
    send_base(VALUE_MAX);
  endtask

  task automatic test_tiny_modulus();
    configure('0, WIDTH'(5));
    send_base(WIDTH'(7));
    configure(WIDTH'(1), WIDTH'(5));
    send_base(WIDTH'(7));
    send_base('0);
  endtask

  task automatic test_base_reduction();
    configure(WIDTH'(1000003), WIDTH'(1));
    send_base(VALUE_MAX);
    send_base(WIDTH'(1000003));
    send_base(WIDTH'(1000002));
  endtask

  task automatic test_extremes();
    base_valid <= 1'b0;
    wait_drained();
    set_reg(MODULUS_ADDR, {1'b1, VALUE_MAX});
    // bit above the register width must be dropped
    set_reg(EXPONENT_ADDR, {1'b1, VALUE_MAX});
    send_base('0);
    send_base(WIDTH'(1));
    send_base(WIDTH'(2));
    send_base(VALUE_MAX - 1);
    configure(VALUE_MAX - 24, VALUE_MAX - 26);
    send_base(WIDTH'(3));
    send_base(VALUE_MAX);
  endtask

  task automatic test_random();
    logic [WIDTH-1:0] m;
    logic [WIDTH-1:0] e;
    logic [WIDTH-1:0] b;
    int phase;
    for (phase = 0; phase < 10; phase++) begin
      case (phase)
        0: begin
          m = VALUE_MAX;
          e = rand_value();
        end
        1: begin
          m = WIDTH'($urandom_range(2, 255));
          e = rand_narrow();
        end
        2: begin
          m = rand_value();
          e = VALUE_MAX;
        end
        default: begin
          m = rand_narrow();
          e = rand_narrow();
        end
      endcase
      if (m < 2) m = m + 2;
      configure(m, e);
      no_idle = (phase == 3);
      repeat (10) begin
        b = $urandom_range(0, 1) ? rand_value() : rand_value() % m;
        send_base(b);
      end
      no_idle = 1'b0;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_exponent_zero();
    test_tiny_modulus();
    test_base_reduction();
    test_extremes();
    test_random();
    base_valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // result checker and receiver stall
  always @(posedge clk) begin
    if (!rst) begin
      if (power_valid && !power_stall) begin
        if (power_q.size() == 0) begin
          report_mismatch("power with no transaction pending", power, '0);
        end else begin
          power_want = power_q.pop_front();
          if (power !== power_want) report_mismatch("power", power, power_want);
        end
        stall_left = no_idle ? 0 : $urandom_range(0, 3);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      power_stall <= (stall_left > 0);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule
